[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, off while reset is high
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// concurrent check that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/psc_pkg.sv]
// types and constants of the predicate stream compactor
package psc_pkg;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int RANGE_BITS     = 16;
  localparam int CAP_BITS       = 6;

  typedef enum logic [1:0] {
    MODE_EVEN  = 2'd0,
    MODE_ODD   = 2'd1,
    MODE_PRIME = 2'd2,
    MODE_RANGE = 2'd3
  } mode_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_MODE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW   = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY    = 4'd3;

  localparam mode_t                 RESET_MODE       = MODE_PRIME;
  localparam logic [RANGE_BITS-1:0] RESET_RANGE_LOW  = 16'd250;
  localparam logic [RANGE_BITS-1:0] RESET_RANGE_HIGH = 16'd650;
  localparam logic [CAP_BITS-1:0]   RESET_CAPACITY   = 6'd16;

  typedef struct packed {
    mode_t                 mode;
    logic [RANGE_BITS-1:0] range_low;
    logic [RANGE_BITS-1:0] range_high;
    logic [CAP_BITS-1:0]   capacity;
  } cfg_t;

  // classification of one queued item
  typedef struct packed {
    logic last;
    logic need_prime;
    logic match;
  } cls_t;

endpackage

[rtl/psc_if.sv]
// stream and configuration interfaces of the predicate stream compactor
interface psc_in_if #(parameter int VALUE_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_item;
  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface psc_out_if #(parameter int VALUE_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] out_value;
  logic                  is_padding;
  logic                  last_result;
  modport source (output valid, output out_value, output is_padding, output last_result,
                  input ready);
  modport sink (input valid, input out_value, input is_padding, input last_result,
                output ready);
endinterface

interface psc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [psc_pkg::CFG_INDEX_BITS-1:0] index;
  logic [psc_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/predicate_stream_compactor.sv]
// top level of the predicate stream compactor
//
//  channel  dir  handshake     payload
//  cfg      in   valid/ready   index, data (register write, always ready)
//  data     in   valid/ready   value, last_item
//  result   out  valid/ready   out_value, is_padding, last_result
//
// even, odd and range items pass through S_IDLE and S_DECIDE in the back end.
// prime items run one S_TRIAL step and a bit-serial S_DIV pass per trial divisor, for up
// to about sqrt(value) divisors, in the single bit-serial remainder unit.
// a last item adds the S_PAD state, which emits padding slots until the capacity is reached.
// synchronous reset loads the register defaults; no clearing pass.
// a stalled result holds the back end when it has a slot to emit; the two-entry queue keeps taking items until full.
module predicate_stream_compactor import psc_pkg::*; #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_SLOTS  = 32
) (
  input  logic      clk,
  input  logic      rst,
  psc_cfg_if.sink   cfg,
  psc_in_if.sink    data,
  psc_out_if.source result
);

  localparam int QW = VALUE_BITS + $bits(cls_t);

  cfg_t                  cfg_regs;
  logic                  push;
  logic [VALUE_BITS-1:0] push_value;
  cls_t                  push_cls;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_data;
  logic [VALUE_BITS-1:0] q_value;
  cls_t                  q_cls;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.mode       <= RESET_MODE;
      cfg_regs.range_low  <= RESET_RANGE_LOW;
      cfg_regs.range_high <= RESET_RANGE_HIGH;
      cfg_regs.capacity   <= RESET_CAPACITY;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FILTER_MODE: cfg_regs.mode <= mode_t'(cfg.data[1:0]);
        REG_RANGE_LOW: cfg_regs.range_low <= cfg.data[RANGE_BITS-1:0];
        REG_RANGE_HIGH: cfg_regs.range_high <= cfg.data[RANGE_BITS-1:0];
        REG_CAPACITY: cfg_regs.capacity <= cfg.data[CAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  psc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .cfg        (cfg_regs),
    .data       (data),
    .full       (q_full),
    .push       (push),
    .push_value (push_value),
    .push_cls   (push_cls)
  );

  psc_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_cls, push_value}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign q_value = q_data[VALUE_BITS-1:0];
  assign q_cls   = cls_t'(q_data[QW-1:VALUE_BITS]);

  psc_back #(.VALUE_BITS(VALUE_BITS), .MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_value (q_value),
    .q_cls   (q_cls),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

[rtl/psc_front.sv]
// front end: accepts items and classifies them against the filter mode
module psc_front import psc_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  cfg_t                  cfg,
  psc_in_if.sink                data,
  input  logic                  full,
  output logic                  push,
  output logic [VALUE_BITS-1:0] push_value,
  output cls_t                  push_cls
);

  localparam int CW = (VALUE_BITS > RANGE_BITS) ? VALUE_BITS : RANGE_BITS;

  logic [CW-1:0] v_ext;
  logic [CW-1:0] lo_ext;
  logic [CW-1:0] hi_ext;

  assign data.ready = !full;
  assign push       = data.valid && !full;
  assign push_value = data.value;

  assign v_ext  = CW'(data.value);
  assign lo_ext = CW'(cfg.range_low);
  assign hi_ext = CW'(cfg.range_high);

  always_comb begin
    push_cls.last       = data.last_item;
    push_cls.need_prime = 1'b0;
    case (cfg.mode)
      MODE_EVEN: push_cls.match = !data.value[0];
      MODE_ODD: push_cls.match = data.value[0];
      MODE_PRIME: begin
        push_cls.match      = 1'b0;
        push_cls.need_prime = 1'b1;
      end
      MODE_RANGE: push_cls.match = (v_ext >= lo_ext) && (v_ext <= hi_ext);
      default: push_cls.match = 1'b0;
    endcase
  end

endmodule

[rtl/psc_fifo.sv]
// short register queue between front and back end
module psc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == NW'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/psc_back.sv]
// back end: trial division prime test, slot counting, padding and result register
module psc_back import psc_pkg::*; #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_SLOTS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  logic [VALUE_BITS-1:0] q_value,
  input  cls_t                  q_cls,
  output logic                  q_pop,
  psc_out_if.source             result
);

  localparam int DW = VALUE_BITS / 2 + 2;
  localparam int SW = 2 * DW;
  localparam int BW = $clog2(VALUE_BITS);
  localparam int KW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIAL,
    S_DIV,
    S_DECIDE,
    S_PAD
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] v;
  logic                  last;
  logic                  match;
  logic [DW-1:0]         d;
  logic [SW-1:0]         sq;
  logic [DW-1:0]         rem;
  logic [BW-1:0]         bit_idx;
  logic [KW-1:0]         kept;

  logic [DW:0]           rem_sh;
  logic [DW:0]           rem_sub;
  logic [DW-1:0]         rem_new;
  logic                  sq_le;
  logic [SW-1:0]         sq_next;
  logic [CAP_BITS:0]     cap_ext;
  logic [KW-1:0]         cap;
  logic                  kept_lt;
  logic [KW-1:0]         kept_inc;
  logic                  fin;
  logic                  out_free;
  logic                  emit;

  // one restoring remainder step per cycle
  assign rem_sh  = {rem, v[bit_idx]};
  assign rem_sub = rem_sh - {1'b0, d};
  assign rem_new = (rem_sh >= {1'b0, d}) ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

  // (d+1)^2 = d^2 + 2d + 1
  assign sq_le   = (sq <= SW'(v));
  assign sq_next = sq + SW'({d, 1'b1});

  assign cap_ext  = {1'b0, cfg.capacity};
  assign cap      = (cap_ext > (CAP_BITS + 1)'(MAX_SLOTS)) ? KW'(MAX_SLOTS) : KW'(cap_ext);
  assign kept_lt  = (kept < cap);
  assign kept_inc = kept + 1'b1;
  assign fin      = (kept_inc == cap);
  assign out_free = !result.valid || result.ready;
  assign emit     = out_free && kept_lt &&
                    (((state == S_DECIDE) && match) || (state == S_PAD));

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      kept         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            v     <= q_value;
            last  <= q_cls.last;
            match <= q_cls.match;
            d     <= DW'(2);
            sq    <= SW'(4);
            if (q_cls.need_prime && (q_value >= VALUE_BITS'(2))) begin
              state <= S_TRIAL;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_TRIAL: begin
          if (sq_le) begin
            rem     <= '0;
            bit_idx <= BW'(VALUE_BITS - 1);
            state   <= S_DIV;
          end else begin
            match <= 1'b1;
            state <= S_DECIDE;
          end
        end
        S_DIV: begin
          rem <= rem_new;
          if (bit_idx == '0) begin
            if (rem_new == '0) begin
              match <= 1'b0;
              state <= S_DECIDE;
            end else begin
              d     <= d + 1'b1;
              sq    <= sq_next;
              state <= S_TRIAL;
            end
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        S_DECIDE: begin
          if (kept_lt && match) begin
            if (out_free) begin
              result.out_value   <= v;
              result.is_padding  <= 1'b0;
              result.last_result <= fin;
              kept               <= kept_inc;
              state              <= last ? S_PAD : S_IDLE;
            end
          end else begin
            state <= last ? S_PAD : S_IDLE;
          end
        end
        S_PAD: begin
          if (kept_lt) begin
            if (out_free) begin
              result.out_value   <= '0;
              result.is_padding  <= 1'b1;
              result.last_result <= fin;
              kept               <= kept_inc;
            end
          end else begin
            kept  <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/psc_checker.sv]
// port-level checks of the predicate stream compactor and their bind
`include "assert_macros.svh"

module psc_checker #(
  parameter int VALUE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [VALUE_BITS-1:0] res_value,
  input logic                  res_padding,
  input logic                  res_last
);

  logic in_pad;

  // padding has started and the final slot is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      in_pad <= 1'b0;
    end else if (res_valid && res_ready) begin
      in_pad <= res_padding && !res_last;
    end
  end

  `ASSERT_ALWAYS(a_no_result_after_reset, clk, rst |=> !res_valid)
  `ASSERT_RUN(a_stall_holds, clk, rst,
    res_valid && !res_ready |=> res_valid && $stable({res_value, res_padding, res_last}))
  `ASSERT_RUN(a_padding_zero, clk, rst, res_valid && res_padding |-> res_value == '0)
  `ASSERT_RUN(a_padding_runs_to_end, clk, rst, res_valid && in_pad |-> res_padding)

endmodule

bind predicate_stream_compactor psc_checker #(.VALUE_BITS(VALUE_BITS)) u_psc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_value   (result.out_value),
  .res_padding (result.is_padding),
  .res_last    (result.last_result)
);

[tb/predicate_stream_compactor_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench of the predicate stream compactor: directed and random data sets
module predicate_stream_compactor_tb;
  import psc_pkg::*;

  localparam int VALUE_BITS    = 16;
  localparam int MAX_SLOTS     = 32;
  localparam int BUSY_CYCLES   = 3 * (VALUE_BITS + 1) * 257 + 64;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 46;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  pad;
    logic                  fin;
  } slot_t;

  class compaction_board;
    mode_t                 mode;
    logic [RANGE_BITS-1:0] low_bound;
    logic [RANGE_BITS-1:0] high_bound;
    logic [CAP_BITS-1:0]   slot_reg;
    int unsigned           kept;
    slot_t                 due_slots[$];
    int                    errors;

    function new();
      mode       = RESET_MODE;
      low_bound  = RESET_RANGE_LOW;
      high_bound = RESET_RANGE_HIGH;
      slot_reg   = RESET_CAPACITY;
      kept       = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        REG_FILTER_MODE: mode = mode_t'(d[1:0]);
        REG_RANGE_LOW: low_bound = d[RANGE_BITS-1:0];
        REG_RANGE_HIGH: high_bound = d[RANGE_BITS-1:0];
        REG_CAPACITY: slot_reg = d[CAP_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit is_prime(int unsigned v);
      int unsigned d;
      if (v < 2) return 1'b0;
      for (d = 2; d * d <= v; d++) begin
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit keeps(logic [VALUE_BITS-1:0] v);
      case (mode)
        MODE_EVEN: return !v[0];
        MODE_ODD: return v[0];
        MODE_PRIME: return is_prime(v);
        default: return v >= low_bound && v <= high_bound;
      endcase
    endfunction

    function void note_value(logic [VALUE_BITS-1:0] v, logic last);
      int unsigned slots;
      slots = (slot_reg > MAX_SLOTS) ? MAX_SLOTS : slot_reg;
      if (kept < slots && keeps(v)) begin
        due_slots.push_back('{v, 1'b0, kept + 1 == slots});
        kept++;
      end
      if (last) begin
        while (kept < slots) begin
          due_slots.push_back('{'0, 1'b1, kept + 1 == slots});
          kept++;
        end
        kept = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_slot(logic [VALUE_BITS-1:0] v, logic pad, logic fin);
      slot_t got;
      slot_t want;
      got = '{v, pad, fin};
      if (due_slots.size() == 0) begin
        report($sformatf("result value %0d pad %b last %b with nothing due", v, pad, fin));
      end else begin
        want = due_slots.pop_front();
        if (got !== want)
          report($sformatf("result value %0d pad %b last %b, due value %0d pad %b last %b",
                           v, pad, fin, want.value, want.pad, want.fin));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   gap_pct;
  compaction_board board;

  psc_cfg_if                          cfg_ch ();
  psc_in_if  #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  psc_out_if #(.VALUE_BITS(VALUE_BITS)) out_ch ();

  predicate_stream_compactor #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_SLOTS (MAX_SLOTS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .data  (in_ch),
    .result(out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #8_000_000;
    $display("predicate_stream_compactor_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_slot(out_ch.out_value, out_ch.is_padding, out_ch.last_result);
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [VALUE_BITS-1:0] v, logic last);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.last_item <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_value(v, last);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    board.write_reg(idx, d);
  endtask

  task automatic set_config(mode_t m, logic [RANGE_BITS-1:0] lo, logic [RANGE_BITS-1:0] hi,
                            logic [CAP_BITS-1:0] cap);
    logic [13:0] junk;
    junk = 14'($urandom);
    write_reg(REG_FILTER_MODE, {junk, m});
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_CAPACITY, {junk[9:0], cap});
    cfg_ch.valid <= 1'b0;
  endtask

  // drain results, then let any item that yields nothing finish its trial division
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.due_slots.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(mode_t m, logic [RANGE_BITS-1:0] lo,
                                                       logic [RANGE_BITS-1:0] hi);
    case (m)
      MODE_PRIME: begin
        if ($urandom_range(0, 15) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 1023));
      end
      MODE_RANGE: begin
        case ($urandom_range(0, 3))
          0: return 16'(lo + $urandom_range(0, 2) - 1);
          1: return 16'(hi + $urandom_range(0, 2) - 1);
          2: return 16'($urandom);
          default: return 16'($urandom_range(lo, hi));
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int                    p;
    int                    i;
    int                    len;
    int                    sent;
    int                    slots;
    mode_t                 m;
    logic [RANGE_BITS-1:0] lo;
    logic [RANGE_BITS-1:0] hi;
    logic [CAP_BITS-1:0]   cap;
    logic                  last;
    logic [CFG_INDEX_BITS-1:0] spare;

    board = new();
    calm    = 1'b0;
    gap_pct = 30;
    rst             <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.last_item <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: prime filter, zero and one rejected, large prime
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd9, 1'b0);
    send_item(16'd65521, 1'b0);
    send_item(16'd65535, 1'b1);
    settle();

    // even filter, set fills up early
    set_config(MODE_EVEN, 16'd0, 16'd65535, 6'd2);
    send_item(16'd0, 1'b0);
    send_item(16'd65535, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd6, 1'b1);
    settle();

    // empty range, capacity beyond the slot count
    set_config(MODE_RANGE, 16'd700, 16'd600, 6'd40);
    send_item(16'd650, 1'b0);
    send_item(16'd0, 1'b1);
    settle();

    // no slots at all
    spare = CFG_INDEX_BITS'(4 + $urandom_range(0, 11));
    write_reg(spare, 16'($urandom));
    set_config(MODE_ODD, 16'd0, 16'd65535, 6'd0);
    send_item(16'd1, 1'b0);
    send_item(16'd3, 1'b1);
    settle();

    // single slot, full range
    set_config(MODE_RANGE, 16'd0, 16'd65535, 6'd1);
    send_item(16'd65535, 1'b1);
    send_item(16'd0, 1'b1);
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      m = mode_t'(p % 4);
      case (p)
        0: cap = 6'd1;
        1: cap = 6'd32;
        2: cap = 6'($urandom_range(4, 20));
        3: cap = 6'd63;
        4: cap = 6'd0;
        5: cap = 6'($urandom_range(33, 63));
        6: cap = 6'd2;
        7: cap = 6'($urandom_range(1, 32));
        8: cap = 6'($urandom_range(1, 8));
        default: cap = 6'($urandom_range(1, 32));
      endcase
      if (p == 3) begin
        lo = 16'd0;
        hi = 16'd65535;
      end else if ($urandom_range(0, 3) == 0) begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end else begin
        lo = 16'($urandom_range(0, 60000));
        hi = 16'(lo + $urandom_range(0, 5000));
      end
      gap_pct = $urandom_range(0, 60);
      calm    = (p == RANDOM_PHASES - 1);
      set_config(m, lo, hi, cap);
      slots = (cap > MAX_SLOTS) ? MAX_SLOTS : cap;
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, slots + 3);
        for (i = 0; i < len && sent < PHASE_ITEMS; i++) begin
          last = (i == len - 1);
          if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
          send_item(pick_value(m, lo, hi), last);
          sent++;
        end
      end
      settle();
    end

    if (board.errors == 0) begin
      $display("predicate_stream_compactor_tb OK");
    end else begin
      $display("predicate_stream_compactor_tb NOT OK");
    end
    $finish;
  end

endmodule
